FILE: rtl/phr_pkg.sv
// Package for the Payne-Hanek argument reduction block.
// Holds payload types, widths, the 2/pi constant table and its lookup helpers.
// No dependencies.
package phr_pkg;

    localparam int MANTISSA_BITS  = 53;
    localparam int TABLE_WORDS    = 20;
    localparam int WORDS_USED_DEF = 5;
    localparam int ROM_SIZE       = 20;

    localparam int WORD_W  = 64;
    localparam int CHUNK_W = 32;
    localparam int FRAC_W  = 128;
    localparam int QUAD_W  = 2;
    localparam int WIN_W   = FRAC_W + QUAD_W;
    localparam int MANT_W  = 53;
    localparam int EXP_W   = 10;
    localparam int K0_W    = EXP_W - 6;
    localparam int IDX_W   = 6;
    localparam int ROM_IDX_W = $clog2(ROM_SIZE);
    // Signed window offset; covers every supported accumulator depth.
    localparam int SHIFT_W = 11;

    typedef struct packed {
        logic [MANT_W-1:0] mantissa;
        logic [EXP_W-1:0]  exponent;
    } t_in;

    typedef struct packed {
        logic [QUAD_W-1:0] quadrant;
        logic [WORD_W-1:0] frac_high;
        logic [WORD_W-1:0] frac_low;
        logic              negative;
    } t_out;

    // Per-transaction tags that ride along the cell chain.
    typedef struct packed {
        logic [MANT_W-1:0]         mant;
        logic [K0_W-1:0]           k0;
        logic signed [SHIFT_W-1:0] shift;
    } t_ctl;

    localparam logic [WORD_W-1:0] ROM_2PI [ROM_SIZE] = '{
        64'hA2F9836E4E441529, 64'hFC2757D1F534DDC0, 64'hDB6295993C439041,
        64'hFE5163ABDEBBC561, 64'hB7246E3A424DD2E0, 64'h06492EEA09D1921C,
        64'hFE1DEB1CB129A73E, 64'hE88235F52EBB4484, 64'hE99C7026B45F7E41,
        64'h3991D639835339F4, 64'h9C845F8BBDF9283B, 64'h1FF897FFDE05980F,
        64'hEF2F118B5A0A6D1F, 64'h6D367ECF27CB09B7, 64'h4F463F669E5FEA2D,
        64'h7527BAC7EBE5F17B, 64'h3D0739F78A5292EA, 64'h6BFB5FB11F8D5D08,
        64'h56033046FC7B6BAB, 64'hF0CFBC209AF4361D
    };

    // Words past the stored expansion read as zero.
    function automatic logic [WORD_W-1:0] rom_word(input logic [IDX_W-1:0] idx);
        logic [WORD_W-1:0] w;
        w = '0;
        if (int'(idx) < ROM_SIZE && int'(idx) < TABLE_WORDS) begin
            w = ROM_2PI[idx[ROM_IDX_W-1:0]];
        end
        return w;
    endfunction

    function automatic logic [CHUNK_W-1:0] rom_chunk(input logic [IDX_W-1:0] idx,
                                                      input logic upper);
        logic [WORD_W-1:0] w;
        w = rom_word(idx);
        return upper ? w[WORD_W-1:CHUNK_W] : w[CHUNK_W-1:0];
    endfunction

endpackage

FILE: rtl/phr_head.sv
// Entry stage of the reduction chain: skip count, window offset, first constant chunk.
// Depends on phr_pkg.
module phr_head #(
    parameter int WORDS_USED = phr_pkg::WORDS_USED_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  phr_pkg::t_in                    i_in_data,
    output logic                            o_valid,
    input  logic                            i_ready,
    output phr_pkg::t_ctl                   o_ctl,
    output logic [phr_pkg::CHUNK_W-1:0]     o_chunk
);

    logic                          r_valid;
    phr_pkg::t_ctl                 r_ctl;
    phr_pkg::t_ctl                 n_ctl;
    logic [phr_pkg::CHUNK_W-1:0]   r_chunk;
    logic [phr_pkg::CHUNK_W-1:0]   n_chunk;
    logic                          en;

    assign en         = !r_valid || i_ready;
    assign o_in_ready = en;

    always_comb begin
        logic [phr_pkg::EXP_W-1:0] skip;
        logic [phr_pkg::K0_W-1:0]  k0;
        int                        s;
        skip = i_in_data.exponent - phr_pkg::EXP_W'(phr_pkg::MANTISSA_BITS + 1);
        k0   = '0;
        if (int'(i_in_data.exponent) > phr_pkg::MANTISSA_BITS + 1) begin
            k0 = skip[phr_pkg::EXP_W-1:6];
        end
        // bit offset of the fraction window inside the accumulator
        s = phr_pkg::MANTISSA_BITS - 1 + phr_pkg::WORD_W * (int'(k0) + WORDS_USED)
            - int'(i_in_data.exponent) - phr_pkg::FRAC_W;
        n_ctl.mant  = i_in_data.mantissa;
        n_ctl.k0    = k0;
        n_ctl.shift = phr_pkg::SHIFT_W'(s);
        n_chunk     = phr_pkg::rom_chunk(phr_pkg::IDX_W'(k0), 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ctl   <= n_ctl;
            r_chunk <= n_chunk;
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_chunk = r_chunk;

endmodule

FILE: rtl/phr_cell.sv
// One cell of the product chain: mantissa times one 32-bit chunk of 2/pi, added
// into the passing accumulator; also fetches the chunk for the next cell. Uses phr_pkg.
module phr_cell #(
    parameter int WORDS_USED = phr_pkg::WORDS_USED_DEF,
    parameter int CELL_IDX   = 0
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_valid,
    output logic                                       o_ready,
    input  phr_pkg::t_ctl                              i_ctl,
    input  logic [phr_pkg::CHUNK_W-1:0]                i_chunk,
    input  logic [phr_pkg::WORD_W*(WORDS_USED+1)-1:0]  i_acc,
    output logic                                       o_valid,
    input  logic                                       i_ready,
    output phr_pkg::t_ctl                              o_ctl,
    output logic [phr_pkg::CHUNK_W-1:0]                o_chunk,
    output logic [phr_pkg::WORD_W*(WORDS_USED+1)-1:0]  o_acc
);

    localparam int ACC_W    = phr_pkg::WORD_W * (WORDS_USED + 1);
    localparam int CHUNKS   = 2 * WORDS_USED;
    localparam int OFF      = phr_pkg::CHUNK_W * (CHUNKS - 1 - CELL_IDX);
    localparam int NEXT     = CELL_IDX + 1;
    localparam int NEXT_UP  = ((NEXT % 2) == 0) ? 1 : 0;
    localparam int HAS_NEXT = (NEXT < CHUNKS) ? 1 : 0;
    localparam int LO_W     = 2 * phr_pkg::CHUNK_W;
    localparam int HI_W     = phr_pkg::MANT_W - phr_pkg::CHUNK_W + phr_pkg::CHUNK_W;

    // multiply stage
    logic                          r_m_valid;
    phr_pkg::t_ctl                 r_m_ctl;
    logic [ACC_W-1:0]              r_m_acc;
    logic [LO_W-1:0]               r_p_lo;
    logic [HI_W-1:0]               r_p_hi;
    logic                          m_en;

    // accumulate stage
    logic                          r_valid;
    phr_pkg::t_ctl                 r_ctl;
    logic [ACC_W-1:0]              r_acc;
    logic [ACC_W-1:0]              n_acc;
    logic [phr_pkg::CHUNK_W-1:0]   r_chunk;
    logic [phr_pkg::CHUNK_W-1:0]   n_chunk;
    logic                          a_en;

    assign a_en    = !r_valid || i_ready;
    assign m_en    = !r_m_valid || a_en;
    assign o_ready = m_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            if (m_en) begin
                r_m_valid <= i_valid;
            end
            if (a_en) begin
                r_valid <= r_m_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_en) begin
            r_m_ctl <= i_ctl;
            r_m_acc <= i_acc;
            r_p_lo  <= LO_W'(i_ctl.mant[phr_pkg::CHUNK_W-1:0]) * LO_W'(i_chunk);
            r_p_hi  <= HI_W'(i_ctl.mant[phr_pkg::MANT_W-1:phr_pkg::CHUNK_W]) * HI_W'(i_chunk);
        end
    end

    always_comb begin
        n_acc = r_m_acc + (ACC_W'(r_p_lo) << OFF)
                        + (ACC_W'(r_p_hi) << (OFF + phr_pkg::CHUNK_W));
        n_chunk = '0;
        if (HAS_NEXT != 0) begin
            n_chunk = phr_pkg::rom_chunk(
                phr_pkg::IDX_W'(r_m_ctl.k0) + phr_pkg::IDX_W'(NEXT >> 1),
                NEXT_UP != 0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_en) begin
            r_ctl   <= r_m_ctl;
            r_acc   <= n_acc;
            r_chunk <= n_chunk;
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_acc   = r_acc;
    assign o_chunk = r_chunk;

endmodule

FILE: rtl/phr_tail.sv
// Back end of the reduction: cuts the fraction window out of the accumulator,
// rounds to nearest quadrant and holds the result register. Uses phr_pkg.
module phr_tail #(
    parameter int WORDS_USED = phr_pkg::WORDS_USED_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_valid,
    output logic                                       o_ready,
    input  phr_pkg::t_ctl                              i_ctl,
    input  logic [phr_pkg::WORD_W*(WORDS_USED+1)-1:0]  i_acc,
    output logic                                       o_out_valid,
    input  logic                                       i_out_ready,
    output phr_pkg::t_out                              o_out_data
);

    localparam int ACC_W = phr_pkg::WORD_W * (WORDS_USED + 1);
    localparam int WIN_W = phr_pkg::WIN_W;

    logic                    r_w_valid;
    logic [WIN_W-1:0]        r_win;
    logic [WIN_W-1:0]        n_win;
    logic                    w_en;

    logic                    r_valid;
    phr_pkg::t_out           r_out;
    phr_pkg::t_out           n_out;
    logic                    o_en;

    assign o_en    = !r_valid || i_out_ready;
    assign w_en    = !r_w_valid || o_en;
    assign o_ready = w_en;

    always_comb begin
        logic [phr_pkg::SHIFT_W-1:0] mag;
        logic [ACC_W-1:0]            down;
        logic [ACC_W+WIN_W-1:0]      up;
        // bits outside the accumulator read as zero on either side
        if (i_ctl.shift < 0) begin
            mag   = phr_pkg::SHIFT_W'(-i_ctl.shift);
            up    = {{WIN_W{1'b0}}, i_acc} << mag;
            down  = '0;
            n_win = up[WIN_W-1:0];
        end else begin
            mag   = phr_pkg::SHIFT_W'(i_ctl.shift);
            up    = '0;
            down  = i_acc >> mag;
            n_win = down[WIN_W-1:0];
        end
    end

    always_comb begin
        logic [phr_pkg::FRAC_W-1:0] frac;
        logic [phr_pkg::QUAD_W-1:0] quad;
        frac = r_win[phr_pkg::FRAC_W-1:0];
        quad = r_win[WIN_W-1:phr_pkg::FRAC_W];
        n_out.negative = frac[phr_pkg::FRAC_W-1];
        // half or more: round quadrant up and report the negated remainder
        if (frac[phr_pkg::FRAC_W-1]) begin
            quad = quad + phr_pkg::QUAD_W'(1);
            frac = phr_pkg::FRAC_W'(0) - frac;
        end
        n_out.quadrant  = quad;
        n_out.frac_high = frac[phr_pkg::FRAC_W-1:phr_pkg::WORD_W];
        n_out.frac_low  = frac[phr_pkg::WORD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_valid <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            if (w_en) begin
                r_w_valid <= i_valid;
            end
            if (o_en) begin
                r_valid <= r_w_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_win <= n_win;
        end
        if (o_en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_out;

endmodule

FILE: rtl/payne_hanek_reduction.sv
// Top level of the Payne-Hanek reduction by pi/2: head stage, chain of product
// cells, window/round tail. Depends on phr_pkg, phr_head, phr_cell, phr_tail.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+----------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_in_data  (phr_pkg::t_in)
//  out     | output    | o_out_valid / i_out_ready  | o_out_data (phr_pkg::t_out)
//
// Throughput: one transaction per cycle, sustained while out is not stalled.
// Stages: one head stage, two stages in each of the 2*WORDS_USED cells (53x32
// multiply as two partial products, then accumulate), two tail stages.
// Reset clears only the stage valid flags; data registers are not reset.
// Each stage loads when it is empty or its successor moves, so a stalled output
// fills the empty stages behind it before in backs up.
module payne_hanek_reduction #(
    parameter int WORDS_USED = phr_pkg::WORDS_USED_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  phr_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output phr_pkg::t_out  o_out_data
);

    localparam int ACC_W  = phr_pkg::WORD_W * (WORDS_USED + 1);
    localparam int CHUNKS = 2 * WORDS_USED;

    logic                          v     [0:CHUNKS];
    logic                          rdy   [0:CHUNKS];
    phr_pkg::t_ctl                 ctl   [0:CHUNKS];
    logic [ACC_W-1:0]              acc   [0:CHUNKS];
    logic [phr_pkg::CHUNK_W-1:0]   chunk [0:CHUNKS-1];

    assign acc[0] = '0;

    phr_head #(
        .WORDS_USED (WORDS_USED)
    ) u_head (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_valid    (v[0]),
        .i_ready    (rdy[0]),
        .o_ctl      (ctl[0]),
        .o_chunk    (chunk[0])
    );

    for (genvar c = 0; c < CHUNKS; c++) begin : g_cell
        if (c < CHUNKS - 1) begin : g_mid
            phr_cell #(
                .WORDS_USED (WORDS_USED),
                .CELL_IDX   (c)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (v[c]),
                .o_ready (rdy[c]),
                .i_ctl   (ctl[c]),
                .i_chunk (chunk[c]),
                .i_acc   (acc[c]),
                .o_valid (v[c+1]),
                .i_ready (rdy[c+1]),
                .o_ctl   (ctl[c+1]),
                .o_chunk (chunk[c+1]),
                .o_acc   (acc[c+1])
            );
        end else begin : g_last
            phr_cell #(
                .WORDS_USED (WORDS_USED),
                .CELL_IDX   (c)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (v[c]),
                .o_ready (rdy[c]),
                .i_ctl   (ctl[c]),
                .i_chunk (chunk[c]),
                .i_acc   (acc[c]),
                .o_valid (v[c+1]),
                .i_ready (rdy[c+1]),
                .o_ctl   (ctl[c+1]),
                .o_chunk (),
                .o_acc   (acc[c+1])
            );
        end
    end

    phr_tail #(
        .WORDS_USED (WORDS_USED)
    ) u_tail (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (v[CHUNKS]),
        .o_ready     (rdy[CHUNKS]),
        .i_ctl       (ctl[CHUNKS]),
        .i_acc       (acc[CHUNKS]),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: rtl/phr_checker.sv
// Port-level checks for payne_hanek_reduction, attached by bind.
// Depends on phr_pkg and the top level's ports.
module phr_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           o_in_ready,
    input  phr_pkg::t_in   i_in_data,
    input  logic           o_out_valid,
    input  logic           i_out_ready,
    input  phr_pkg::t_out  o_out_data
);

    // an offered argument stays put until the block takes it
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_data))
        else $error("input transaction changed before acceptance");

    // a pending result transaction is not withdrawn
    a_out_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output valid dropped before transaction");

    a_out_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("output payload changed while stalled");

    // rounding leaves at most one half; exactly one half only on the negative side
    a_frac_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_out_data.frac_high[phr_pkg::WORD_W-1] ||
                         (o_out_data.negative &&
                          o_out_data.frac_high == {1'b1, {(phr_pkg::WORD_W-1){1'b0}}} &&
                          o_out_data.frac_low == '0)))
        else $error("remainder exceeds one half");

    // pipeline flushed by reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind payne_hanek_reduction phr_checker u_phr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
